FILE: sv/ctq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Class task queue package
// Shared types, codes and a helper function of the class task queue.
// ----------------------------------------------------------------------------
package ctq_pkg;

    // Operation selector carried in the input tuser.
    typedef enum logic [1:0] {
        FUNC_SUBMIT = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_DRAIN  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // Result kinds.
    localparam logic [2:0] KIND_ADMIT    = 3'd0;
    localparam logic [2:0] KIND_DROP     = 3'd1;
    localparam logic [2:0] KIND_DISPATCH = 3'd2;
    localparam logic [2:0] KIND_EMPTY    = 3'd3;
    localparam logic [2:0] KIND_DRAINED  = 3'd4;

    // Admission codes.
    localparam logic [2:0] ADMIT_ACCEPTED = 3'd0;
    localparam logic [2:0] ADMIT_REPLACED = 3'd1;
    localparam logic [2:0] ADMIT_FOLDED   = 3'd2;
    localparam logic [2:0] ADMIT_EXPIRED  = 3'd3;
    localparam logic [2:0] ADMIT_FULL     = 3'd4;

    // Drop reasons.
    localparam logic [2:0] DROP_NONE       = 3'd0;
    localparam logic [2:0] DROP_SUPERSEDED = 3'd1;
    localparam logic [2:0] DROP_STALE      = 3'd2;
    localparam logic [2:0] DROP_EXPIRED    = 3'd3;
    localparam logic [2:0] DROP_SHUTDOWN   = 3'd4;

    // Task classes: interactive and background fold and supersede; CLASS_LAST is the last class scanned.
    localparam logic [1:0] CLASS_INTERACTIVE = 2'd1;
    localparam logic [1:0] CLASS_BACKGROUND  = 2'd2;
    localparam logic [1:0] CLASS_LAST        = 2'd3;

    // Bus widths.
    localparam int S_TDATA_W = 264;
    localparam int M_TDATA_W = 208;

    // Classified command handed from the front to the back.
    typedef struct packed {
        func_t       op;
        logic [1:0]  cls;
        logic [31:0] doc;
        logic [31:0] rev;
        logic [31:0] gen;
        logic        dlv;
        logic [63:0] dl;
        logic [63:0] now;
        logic [31:0] cur;
        logic        expired;
    } cmd_t;

    // One stored task.
    typedef struct packed {
        logic [1:0]  cls;
        logic [31:0] doc;
        logic [31:0] rev;
        logic [31:0] gen;
        logic        dlv;
        logic [63:0] dl;
        logic [31:0] id;
    } entry_t;

    // One result word.
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  admit_code;
        logic [2:0]  drop_status;
        logic [31:0] id;
        logic [1:0]  cls;
        logic [31:0] doc;
        logic [31:0] rev;
        logic [31:0] gen;
        logic        dlv;
        logic [63:0] dl;
        logic        last;
    } result_t;

    // Scan pass of the back end.
    typedef enum logic [1:0] {
        PH_FOLD  = 2'd0,
        PH_EVICT = 2'd1,
        PH_POP   = 2'd2,
        PH_DRAIN = 2'd3
    } phase_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_READ  = 3'd1,
        ST_EVAL  = 3'd2,
        ST_STORE = 3'd3,
        ST_FINAL = 3'd4
    } state_t;

    // Result word that reports a stored entry.
    function automatic result_t entry_result(input logic [2:0] kind,
                                             input logic [2:0] status,
                                             input entry_t e,
                                             input logic last);
        result_t r;
        r             = '0;
        r.kind        = kind;
        r.drop_status = status;
        r.id          = e.id;
        r.cls         = e.cls;
        r.doc         = e.doc;
        r.rev         = e.rev;
        r.gen         = e.gen;
        r.dlv         = e.dlv;
        r.dl          = e.dl;
        r.last        = last;
        return r;
    endfunction

endpackage

FILE: sv/ctq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Class task queue front end
// Accepts input words, unpacks and classifies them, and queues the commands
// for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module ctq_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: task_class, document, revision, task_generation,
    // deadline_valid, deadline_time, now_time, live generation, zero fill
    input  logic [ctq_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: func
    input  logic [1:0]                      s_tuser,
    output logic                            q_valid,
    input  logic                            q_ready,
    output ctq_pkg::cmd_t                   q_cmd
);
    import ctq_pkg::*;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       in_cmd;
    logic       push;
    logic       pop;

    // Unpack the word and flag a deadline that has already passed.
    always_comb begin
        in_cmd         = '0;
        in_cmd.op      = func_t'(s_tuser);
        in_cmd.cls     = s_tdata[1:0];
        in_cmd.doc     = s_tdata[33:2];
        in_cmd.rev     = s_tdata[65:34];
        in_cmd.gen     = s_tdata[97:66];
        in_cmd.dlv     = s_tdata[98];
        in_cmd.dl      = s_tdata[162:99];
        in_cmd.now     = s_tdata[226:163];
        in_cmd.cur     = s_tdata[258:227];
        in_cmd.expired = s_tdata[98] && (s_tdata[226:163] > s_tdata[162:99]);
    end

    // Unknown operations are taken and discarded.
    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready && (func_t'(s_tuser) != FUNC_NONE);
    assign pop      = q_valid && q_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = fifo_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("front queue count out of range");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != 2'd0) else $error("front queue popped while empty");
    a_none_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && func_t'(s_tuser) == FUNC_NONE && !pop)
        |=> cnt_reg == $past(cnt_reg)) else $error("unknown operation was queued");

endmodule

FILE: sv/ctq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Class task queue back end
// Holds the task table and its age order, walks it one entry at a time for
// each command, and emits result words through an output register.
// ----------------------------------------------------------------------------
module ctq_back #(
    parameter int NUM_SLOTS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  ctq_pkg::cmd_t     q_cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output ctq_pkg::result_t  res
);
    import ctq_pkg::*;

    localparam int PW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(NUM_SLOTS);

    // Task table memory with registered read.
    entry_t          mem [NUM_SLOTS];
    entry_t          rd_q_reg;

    // Age order: positions below count_reg hold live slots oldest first,
    // the rest hold free slots.
    logic [PW-1:0]   perm_reg [NUM_SLOTS];
    logic [CW-1:0]   count_reg, count_next;
    logic [31:0]     next_id_reg, next_id_next;

    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    cmd_t            cmd_reg, cmd_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [1:0]      cls_reg, cls_next;
    logic            evicted_reg, evicted_next;
    logic [2:0]      lastwhy_reg, lastwhy_next;
    logic [2:0]      fin_kind_reg, fin_kind_next;
    logic [2:0]      fin_code_reg, fin_code_next;

    logic            out_valid_reg;
    result_t         out_reg;

    logic            out_free;
    logic            rd_en;
    logic [PW-1:0]   rd_addr;
    logic            wr_en;
    logic [PW-1:0]   wr_addr;
    entry_t          wr_data;
    logic            remove;
    logic            emit;
    result_t         emit_res;
    logic            same_doc;
    logic [31:0]     id_inc;

    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign q_ready   = (state_reg == ST_IDLE);
    assign same_doc  = (rd_q_reg.cls == cmd_reg.cls) && (rd_q_reg.doc == cmd_reg.doc);
    assign id_inc    = next_id_reg + 32'd1;

    // Sequencer: next state and per-cycle actions.
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cmd_next      = cmd_reg;
        pos_next      = pos_reg;
        cls_next      = cls_reg;
        evicted_next  = evicted_reg;
        lastwhy_next  = lastwhy_reg;
        fin_kind_next = fin_kind_reg;
        fin_code_next = fin_code_reg;
        count_next    = count_reg;
        next_id_next  = next_id_reg;
        rd_en         = 1'b0;
        rd_addr       = perm_reg[pos_reg[PW-1:0]];
        wr_en         = 1'b0;
        wr_addr       = perm_reg[count_reg[PW-1:0]];
        wr_data       = '0;
        remove        = 1'b0;
        emit          = 1'b0;
        emit_res      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cmd_next      = q_cmd;
                    pos_next      = '0;
                    cls_next      = '0;
                    evicted_next  = 1'b0;
                    lastwhy_next  = DROP_NONE;
                    fin_code_next = ADMIT_ACCEPTED;
                    case (q_cmd.op)
                        FUNC_SUBMIT: begin
                            fin_kind_next = KIND_ADMIT;
                            if (q_cmd.expired) begin
                                fin_code_next = ADMIT_EXPIRED;
                                state_next    = ST_FINAL;
                            end else if (q_cmd.cls == CLASS_INTERACTIVE ||
                                         q_cmd.cls == CLASS_BACKGROUND) begin
                                phase_next = PH_FOLD;
                                state_next = ST_READ;
                            end else begin
                                state_next = ST_STORE;
                            end
                        end
                        FUNC_POP: begin
                            fin_kind_next = KIND_EMPTY;
                            phase_next    = PH_POP;
                            state_next    = ST_READ;
                        end
                        FUNC_DRAIN: begin
                            fin_kind_next = KIND_DRAINED;
                            phase_next    = PH_DRAIN;
                            state_next    = ST_READ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Issue the read of the entry at the scan position, or close the pass.
            ST_READ: begin
                if (pos_reg >= count_reg) begin
                    pos_next = '0;
                    case (phase_reg)
                        PH_FOLD:  phase_next = PH_EVICT;
                        PH_EVICT: state_next = ST_STORE;
                        default: begin
                            if (cls_reg == CLASS_LAST) begin
                                state_next = ST_FINAL;
                            end else begin
                                cls_next = cls_reg + 2'd1;
                            end
                        end
                    endcase
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_EVAL;
                end
            end

            // Judge the entry that was read.
            ST_EVAL: begin
                state_next = ST_READ;
                case (phase_reg)
                    PH_FOLD: begin
                        if (same_doc && rd_q_reg.rev >= cmd_reg.rev) begin
                            fin_code_next = ADMIT_FOLDED;
                            state_next    = ST_FINAL;
                        end else begin
                            pos_next = pos_reg + CW'(1);
                        end
                    end
                    PH_EVICT: begin
                        if (same_doc && rd_q_reg.rev < cmd_reg.rev) begin
                            if (out_free) begin
                                emit         = 1'b1;
                                emit_res     = entry_result(KIND_DROP, DROP_SUPERSEDED,
                                                            rd_q_reg, 1'b0);
                                remove       = 1'b1;
                                count_next   = count_reg - CW'(1);
                                evicted_next = 1'b1;
                            end else begin
                                state_next = ST_EVAL;
                            end
                        end else begin
                            pos_next = pos_reg + CW'(1);
                        end
                    end
                    PH_POP: begin
                        if (rd_q_reg.cls != cls_reg) begin
                            pos_next = pos_reg + CW'(1);
                        end else if (!out_free) begin
                            state_next = ST_EVAL;
                        end else begin
                            emit       = 1'b1;
                            remove     = 1'b1;
                            count_next = count_reg - CW'(1);
                            if (rd_q_reg.gen != cmd_reg.cur) begin
                                emit_res     = entry_result(KIND_DROP, DROP_STALE,
                                                            rd_q_reg, 1'b0);
                                lastwhy_next = DROP_STALE;
                            end else if (rd_q_reg.dlv && cmd_reg.now > rd_q_reg.dl) begin
                                emit_res     = entry_result(KIND_DROP, DROP_EXPIRED,
                                                            rd_q_reg, 1'b0);
                                lastwhy_next = DROP_EXPIRED;
                            end else begin
                                emit_res   = entry_result(KIND_DISPATCH, DROP_NONE,
                                                          rd_q_reg, 1'b1);
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    default: begin
                        if (rd_q_reg.cls != cls_reg) begin
                            pos_next = pos_reg + CW'(1);
                        end else if (out_free) begin
                            emit       = 1'b1;
                            emit_res   = entry_result(KIND_DROP, DROP_SHUTDOWN,
                                                      rd_q_reg, 1'b0);
                            remove     = 1'b1;
                            count_next = count_reg - CW'(1);
                        end else begin
                            state_next = ST_EVAL;
                        end
                    end
                endcase
            end

            // Store a new task in the first free slot, or reject on a full table.
            ST_STORE: begin
                if (out_free) begin
                    emit          = 1'b1;
                    emit_res      = '0;
                    emit_res.kind = KIND_ADMIT;
                    emit_res.last = 1'b1;
                    state_next    = ST_IDLE;
                    if (count_reg == FULL_COUNT) begin
                        emit_res.admit_code = ADMIT_FULL;
                    end else begin
                        wr_en               = 1'b1;
                        wr_data.cls         = cmd_reg.cls;
                        wr_data.doc         = cmd_reg.doc;
                        wr_data.rev         = cmd_reg.rev;
                        wr_data.gen         = cmd_reg.gen;
                        wr_data.dlv         = cmd_reg.dlv;
                        wr_data.dl          = cmd_reg.dl;
                        wr_data.id          = next_id_reg;
                        emit_res.admit_code = evicted_reg ? ADMIT_REPLACED : ADMIT_ACCEPTED;
                        emit_res.id         = next_id_reg;
                        count_next          = count_reg + CW'(1);
                        next_id_next        = (id_inc == 32'd0) ? 32'd1 : id_inc;
                    end
                end
            end

            // Closing word of the command.
            ST_FINAL: begin
                if (out_free) begin
                    emit                 = 1'b1;
                    emit_res             = '0;
                    emit_res.kind        = fin_kind_reg;
                    emit_res.admit_code  = fin_code_reg;
                    emit_res.drop_status = (fin_kind_reg == KIND_EMPTY) ? lastwhy_reg
                                                                        : DROP_NONE;
                    emit_res.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Table memory.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // Command payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        if (emit) begin
            out_reg <= emit_res;
        end
    end

    // Control state and age order.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_FOLD;
            pos_reg       <= '0;
            cls_reg       <= '0;
            evicted_reg   <= 1'b0;
            lastwhy_reg   <= DROP_NONE;
            fin_kind_reg  <= KIND_ADMIT;
            fin_code_reg  <= ADMIT_ACCEPTED;
            count_reg     <= '0;
            next_id_reg   <= 32'd1;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < NUM_SLOTS; j++) begin
                perm_reg[j] <= PW'(j);
            end
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            cls_reg      <= cls_next;
            evicted_reg  <= evicted_next;
            lastwhy_reg  <= lastwhy_next;
            fin_kind_reg <= fin_kind_next;
            fin_code_reg <= fin_code_next;
            count_reg    <= count_next;
            next_id_reg  <= next_id_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
            // Removal closes the gap and parks the freed slot at the end.
            if (remove) begin
                for (int j = 0; j < NUM_SLOTS - 1; j++) begin
                    if (CW'(j) >= pos_reg) begin
                        perm_reg[j] <= perm_reg[j + 1];
                    end
                end
                perm_reg[NUM_SLOTS - 1] <= perm_reg[pos_reg[PW-1:0]];
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT) else $error("task count exceeds table size");
    a_store_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> count_reg < FULL_COUNT) else $error("store into a full table");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free) else $error("result overwritten before it was taken");
    a_remove_live: assert property (@(posedge aclk) disable iff (!aresetn)
        remove |-> pos_reg < count_reg) else $error("removal outside live entries");

endmodule

FILE: sv/class_task_queue_with_supersession.sv
`timescale 1ns / 1ps
// Flow: a command is taken into a two-entry queue while it has room; the back end walks
// the live entries, reading each from memory and then judging it. An interactive or
// background submit makes a fold pass and an evict pass before it stores; pop and drain
// scan each class in turn. Results are one word; one command at a time in the back end.
// Reset: aresetn (synchronous, active low) empties the table and sets the next id to one.
// ----------------------------------------------------------------------------
// Class task queue with supersession
// Shared table of prioritized tasks with folding, supersession, pop and drain.
// ----------------------------------------------------------------------------
module class_task_queue_with_supersession #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: task_class, document, revision, task_generation,
    // deadline_valid, deadline_time, now_time, live generation, zero fill
    input  logic [ctq_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: func
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: admit_code, drop_status, out_task_id, out_class, out_document,
    // out_revision, out_generation, out_deadline_valid, out_deadline, zero fill
    output logic [ctq_pkg::M_TDATA_W-1:0]   m_tdata,
    // tuser: kind
    output logic [2:0]                      m_tuser,
    output logic                            m_tlast
);
    import ctq_pkg::*;

    logic    q_valid;
    logic    q_ready;
    cmd_t    q_cmd;
    result_t res;

    ctq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    ctq_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result word.
    assign m_tdata = {7'd0, res.dl, res.dlv, res.gen, res.rev, res.doc, res.cls,
                      res.id, res.drop_status, res.admit_code};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
